@@ hdl/met_pkg.sv @@
// Shared types and constants for the Mandelbrot escape-time block.
`timescale 1ns / 1ps

package met_pkg;

    // Fixed widths of the port fields.
    localparam int PIX_W      = 12;
    localparam int MIN_W      = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REAL_MIN       = 3'd0,
        REG_IMAG_MIN       = 3'd1,
        REG_REAL_STEP      = 3'd2,
        REG_IMAG_STEP      = 3'd3,
        REG_MAX_ITERATIONS = 3'd4
    } met_reg_idx_t;

    // Register values after reset.
    localparam logic signed [MIN_W-1:0] RST_REAL_MIN       = -32'sd536870912;
    localparam logic signed [MIN_W-1:0] RST_IMAG_MIN       = -32'sd536870912;
    localparam logic [STEP_W-1:0]       RST_REAL_STEP      = 31'd1048576;
    localparam logic [STEP_W-1:0]       RST_IMAG_STEP      = 31'd1048576;
    localparam logic [ITER_W-1:0]       RST_MAX_ITERATIONS = 17'd100000;

    typedef struct packed {
        logic signed [MIN_W-1:0] real_min;
        logic signed [MIN_W-1:0] imag_min;
        logic [STEP_W-1:0]       real_step;
        logic [STEP_W-1:0]       imag_step;
        logic [ITER_W-1:0]       max_iterations;
    } met_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_pixel;
        logic coord_mul;
        logic coord_add;
        logic square;
        logic iterate;
        logic load_result;
    } met_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finish;
    } met_status_t;

endpackage

@@ hdl/mandelbrot_escape_time_top.sv @@
// Top level of the Mandelbrot escape-time block: register file and unit wiring.
`timescale 1ns / 1ps

//  Channel   Handshake              Payload per beat
//  --------  ---------------------  --------------------------------------------
//  in        in_valid / in_stall    pixel_column[11:0], pixel_row[11:0]
//  out       out_valid / out_stall  escape_count[16:0]
//  cfg       cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[31:0]
//
// Each pixel is mapped to its point c and then iterated; each iteration forms the
// three products of z in registered multipliers and then tests and updates z.
// Reset clears the controller and loads the configuration registers with their
// defaults (both minimums -2.0, steps of 1/256, 100000 iterations).
// A new pixel is taken as soon as the previous result sits in the output register;
// the result waits there while out_stall is high, and only a second finished pixel
// behind it holds the loop.

module mandelbrot_escape_time_top #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 28
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Pixel input channel.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [met_pkg::PIX_W-1:0]      pixel_column,
    input  logic [met_pkg::PIX_W-1:0]      pixel_row,
    // Result channel.
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [met_pkg::ITER_W-1:0]     escape_count,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0] cfg_data
);
    import met_pkg::*;

    met_cfg_t    cfg_reg;
    met_cmd_t    cmd;
    met_status_t status;

    // Registers are to be written only while no pixel is in flight; the block does not
    // enforce this. cfg_ready is tied high, so a write can always complete at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_min       <= RST_REAL_MIN;
            cfg_reg.imag_min       <= RST_IMAG_MIN;
            cfg_reg.real_step      <= RST_REAL_STEP;
            cfg_reg.imag_step      <= RST_IMAG_STEP;
            cfg_reg.max_iterations <= RST_MAX_ITERATIONS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Indexes past the last register are dropped.
            case (cfg_index)
                REG_REAL_MIN:       cfg_reg.real_min       <= cfg_data;
                REG_IMAG_MIN:       cfg_reg.imag_min       <= cfg_data;
                REG_REAL_STEP:      cfg_reg.real_step      <= cfg_data[STEP_W-1:0];
                REG_IMAG_STEP:      cfg_reg.imag_step      <= cfg_data[STEP_W-1:0];
                REG_MAX_ITERATIONS: cfg_reg.max_iterations <= cfg_data[ITER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The controller owns the pixel and result handshakes; the datapath holds all arithmetic.
    met_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    met_dp #(
        .CW (COORD_WIDTH),
        .FB (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .status       (status),
        .escape_count (escape_count)
    );

endmodule

@@ hdl/met_dp.sv @@
// Datapath: point mapping, z update with saturation, escape test and iteration count.
`timescale 1ns / 1ps

module met_dp #(
    parameter int CW = 32,
    parameter int FB = 28
) (
    input  logic                        clk,
    input  met_pkg::met_cfg_t           cfg,
    input  met_pkg::met_cmd_t           cmd,
    input  logic [met_pkg::PIX_W-1:0]   pixel_column,
    input  logic [met_pkg::PIX_W-1:0]   pixel_row,
    output met_pkg::met_status_t        status,
    output logic [met_pkg::ITER_W-1:0]  escape_count
);
    import met_pkg::*;

    localparam int PW     = 2 * CW;
    localparam int SQ_W   = PW - FB;
    localparam int XY_W   = SQ_W + 1;
    localparam int SUM_W  = SQ_W + 2;
    localparam int MAG_W  = SQ_W + 1;
    localparam int CP_W   = PIX_W + STEP_W;
    localparam int CS_W   = CP_W + 2;
    localparam int WIDE_W = (SUM_W > CS_W) ? SUM_W : CS_W;

    localparam logic signed [MAG_W-1:0] ESC_BOUND = MAG_W'(4) << FB;

    logic [PIX_W-1:0]         col_reg;
    logic [PIX_W-1:0]         row_reg;
    logic [CP_W-1:0]          cre_prod_reg;
    logic [CP_W-1:0]          cim_prod_reg;
    logic signed [CW-1:0]     c_re_reg;
    logic signed [CW-1:0]     c_im_reg;
    logic signed [CW-1:0]     x_reg;
    logic signed [CW-1:0]     y_reg;
    logic signed [PW-1:0]     xx_prod_reg;
    logic signed [PW-1:0]     yy_prod_reg;
    logic signed [PW-1:0]     xy_prod_reg;
    logic [ITER_W-1:0]        count_reg;
    logic [ITER_W-1:0]        escape_count_reg;

    logic signed [WIDE_W-1:0] cre_sum;
    logic signed [WIDE_W-1:0] cim_sum;
    logic signed [PW-1:0]     xx_full;
    logic signed [PW-1:0]     yy_full;
    logic signed [PW-1:0]     xy_full;
    logic signed [SQ_W-1:0]   xx_fl;
    logic signed [SQ_W-1:0]   yy_fl;
    logic signed [XY_W-1:0]   xy2_fl;
    logic signed [WIDE_W-1:0] re_sum;
    logic signed [WIDE_W-1:0] im_sum;
    logic signed [MAG_W-1:0]  mag;
    logic [ITER_W-1:0]        limit;
    logic                     escaped;

    // Clamp a wide signed sum to the coordinate range.
    function automatic logic signed [CW-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-CW:0]   upper;
        logic signed [CW-1:0] res;
        upper = v[WIDE_W-1:CW-1];
        if ((&upper) || !(|upper)) begin
            res = v[CW-1:0];
        end
        else if (v[WIDE_W-1]) begin
            res = {1'b1, {(CW-1){1'b0}}};
        end
        else begin
            res = {1'b0, {(CW-1){1'b1}}};
        end
        sat_coord = res;
    endfunction

    // Point on the complex plane.
    assign cre_sum = WIDE_W'(signed'(cfg.real_min)) + WIDE_W'(signed'({1'b0, cre_prod_reg}));
    assign cim_sum = WIDE_W'(signed'(cfg.imag_min)) + WIDE_W'(signed'({1'b0, cim_prod_reg}));

    // Arithmetic shifts of the products round toward minus infinity.
    assign xx_full = xx_prod_reg >>> FB;
    assign yy_full = yy_prod_reg >>> FB;
    assign xy_full = xy_prod_reg >>> (FB - 1);
    assign xx_fl   = xx_full[SQ_W-1:0];
    assign yy_fl   = yy_full[SQ_W-1:0];
    assign xy2_fl  = xy_full[XY_W-1:0];

    assign re_sum = WIDE_W'(xx_fl) - WIDE_W'(yy_fl) + WIDE_W'(c_re_reg);
    assign im_sum = WIDE_W'(xy2_fl) + WIDE_W'(c_im_reg);

    // The squares of the current z serve both the escape test and the update.
    assign mag     = MAG_W'(xx_fl) + MAG_W'(yy_fl);
    assign escaped = (mag >= ESC_BOUND);
    assign limit   = (cfg.max_iterations == '0) ? ITER_W'(1) : cfg.max_iterations;

    assign status.finish = escaped || (count_reg >= limit);
    assign escape_count  = escape_count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            col_reg <= pixel_column;
            row_reg <= pixel_row;
        end
        if (cmd.coord_mul)
        begin
            cre_prod_reg <= CP_W'(col_reg) * CP_W'(cfg.real_step);
            cim_prod_reg <= CP_W'(row_reg) * CP_W'(cfg.imag_step);
        end
        if (cmd.coord_add)
        begin
            c_re_reg  <= sat_coord(cre_sum);
            c_im_reg  <= sat_coord(cim_sum);
            x_reg     <= '0;
            y_reg     <= '0;
            count_reg <= '0;
        end
        if (cmd.square)
        begin
            xx_prod_reg <= x_reg * x_reg;
            yy_prod_reg <= y_reg * y_reg;
            xy_prod_reg <= x_reg * y_reg;
        end
        if (cmd.iterate)
        begin
            x_reg     <= sat_coord(re_sum);
            y_reg     <= sat_coord(im_sum);
            count_reg <= count_reg + ITER_W'(1);
        end
        if (cmd.load_result)
        begin
            escape_count_reg <= count_reg;
        end
    end

endmodule

@@ hdl/met_ctrl.sv @@
// Controller: sequences one pixel through mapping and the iteration loop.
`timescale 1ns / 1ps

module met_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  met_pkg::met_status_t  status,
    output met_pkg::met_cmd_t     cmd
);
    import met_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_COORD_MUL = 6'b000010,
        ST_COORD_ADD = 6'b000100,
        ST_SQUARE    = 6'b001000,
        ST_UPDATE    = 6'b010000,
        ST_DONE      = 6'b100000
    } met_state_t;

    met_state_t state_reg;
    met_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = ST_COORD_MUL;
                end
            end
            ST_COORD_MUL:
            begin
                cmd.coord_mul = 1'b1;
                state_next    = ST_COORD_ADD;
            end
            ST_COORD_ADD:
            begin
                cmd.coord_add = 1'b1;
                state_next    = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.finish)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.iterate = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/met_checker.sv @@
// Port-level checks for the Mandelbrot escape-time block and their binding.
`timescale 1ns / 1ps

module met_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [met_pkg::ITER_W-1:0]    escape_count
);

    // The block works on one pixel at a time, so an input beat closes the port.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input port still open after a pixel beat");

    // A new result is only presented at the end of a pixel's run.
    a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a pixel in flight");

    // Every pixel performs at least one iteration.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (escape_count != '0))
        else $error("zero escape count presented");

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(escape_count)))
        else $error("stalled result changed or dropped");

endmodule

bind mandelbrot_escape_time_top met_checker u_met_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .escape_count (escape_count)
);

@@ tb/sv/tb_mandelbrot_escape_time_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Mandelbrot escape-time block.

module tb_mandelbrot_escape_time_top;
    import met_pkg::*;

    // Fixed-point format of the coordinates: Q4.28 held in 32 bits.
    localparam int     FRAC      = 28;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;
    localparam longint ESC_BOUND = longint'(4) << FRAC;

    // Longest idle stretch that either side may insert, in cycles.
    localparam int LONG_IDLE = 30;

    // One pixel waiting to be sent. A set hold bit makes the sender wait
    // until every escape count already owed has come back.
    typedef struct {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        bit               hold;
    } pixel_req_t;

    // Every block input starts at a known value before the first edge.
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_column = '0;
    logic [PIX_W-1:0]      pixel_row    = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [ITER_W-1:0]     escape_count;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Shadow copy of the plane registers, kept as wide signed integers so
    // that the escape-count arithmetic below never overflows.
    longint sh_real_min;
    longint sh_imag_min;
    longint sh_real_step;
    longint sh_imag_step;
    longint sh_max_iter;

    pixel_req_t        pixel_q[$];
    pixel_req_t        next_pix;
    logic [ITER_W-1:0] counts_due[$];
    logic [ITER_W-1:0] want_count;
    logic [ITER_W-1:0] lo_count = '1;
    logic [ITER_W-1:0] hi_count = '0;

    int     errors       = 0;
    int     results_seen = 0;
    int     settings     = 1;
    int     send_gap     = 0;
    int     stall_left   = 0;
    int     free_left    = 0;
    bit     quiet        = 1'b0;
    longint cycle_cnt    = 0;
    longint cycle_budget = 200;

    mandelbrot_escape_time_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_count (escape_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Clamp a wide intermediate to the signed 32-bit coordinate range.
    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return v;
    endfunction

    // Escape count of one pixel under the current plane registers. The
    // squares are floored by an arithmetic shift of the full product, and
    // 2xy comes from shifting x*y one place less. The bound test on |z|^2
    // is made before every iteration, so the count is never below one.
    function automatic logic [ITER_W-1:0] escape_time_of(input logic [PIX_W-1:0] col,
                                                         input logic [PIX_W-1:0] row);
        longint c_re;
        longint c_im;
        longint x;
        longint y;
        longint xx;
        longint yy;
        longint xy2;
        longint mag;
        longint lim;
        longint n;
        c_re = clamp_q(sh_real_min + longint'(col) * sh_real_step);
        c_im = clamp_q(sh_imag_min + longint'(row) * sh_imag_step);
        lim  = (sh_max_iter == 0) ? 1 : sh_max_iter;
        x    = 0;
        y    = 0;
        mag  = 0;
        n    = 0;
        while (n < lim && mag < ESC_BOUND)
        begin
            xx  = (x * x) >>> FRAC;
            yy  = (y * y) >>> FRAC;
            xy2 = (x * y) >>> (FRAC - 1);
            x   = clamp_q(xx - yy + c_re);
            y   = clamp_q(xy2 + c_im);
            mag = ((x * x) >>> FRAC) + ((y * y) >>> FRAC);
            n++;
        end
        return n[ITER_W-1:0];
    endfunction

    // Mirror one register write into the shadow copy, with the same
    // truncation to register width that the hardware applies.
    function automatic void apply_reg(input met_reg_idx_t idx, input logic [31:0] d);
        case (idx)
            REG_REAL_MIN:       sh_real_min  = longint'(signed'(d));
            REG_IMAG_MIN:       sh_imag_min  = longint'(signed'(d));
            REG_REAL_STEP:      sh_real_step = longint'(d[STEP_W-1:0]);
            REG_IMAG_STEP:      sh_imag_step = longint'(d[STEP_W-1:0]);
            REG_MAX_ITERATIONS: sh_max_iter  = longint'(d[ITER_W-1:0]);
            default:            ;
        endcase
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    // A quiet phase runs both channels flat out.
    function automatic int idle_len();
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, LONG_IDLE);
    endfunction

    // Queue a pixel and extend the run limit by the slowest time it may
    // legally take: the full iteration limit, the fixed overhead, and the
    // longest idle stretch on each side.
    task automatic queue_pixel(input int col, input int row, input bit hold);
        pixel_req_t p;
        longint     eff;
        p.col  = col[PIX_W-1:0];
        p.row  = row[PIX_W-1:0];
        p.hold = hold;
        pixel_q.push_back(p);
        eff = (sh_max_iter == 0) ? 1 : sh_max_iter;
        cycle_budget += 2 * eff + 5 + 2 * LONG_IDLE + 8;
    endtask

    // Wait until the sender has nothing left and every owed count is back,
    // then let the block settle.
    task automatic drain();
        while (pixel_q.size() != 0 || in_valid || counts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // Program all five plane registers back to back on the configuration
    // channel, only once the block is idle. Bits above each register's
    // width are filled with noise, since the hardware must drop them.
    task automatic set_plane(input logic [31:0] rmin, input logic [31:0] imin,
                             input logic [31:0] rstep, input logic [31:0] istep,
                             input logic [31:0] maxit);
        met_reg_idx_t regs[5];
        logic [31:0]  vals[5];
        rstep[31]    = 1'($urandom_range(0, 1));
        istep[31]    = 1'($urandom_range(0, 1));
        maxit[31:17] = 15'($urandom);
        regs = '{REG_REAL_MIN, REG_IMAG_MIN, REG_REAL_STEP, REG_IMAG_STEP,
                 REG_MAX_ITERATIONS};
        vals = '{rmin, imin, rstep, istep, maxit};
        drain();
        settings++;
        cycle_budget += 200;
        for (int k = 0; k < 5; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_reg(regs[k], vals[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Pixel sender. A beat that was accepted at this edge is predicted at
    // once, so the owed count is queued before any later beat can be.
    // The next beat goes out only when the slot is free, after its random
    // gap, and for a hold item only once nothing is owed any more. Each
    // output gets at most one nonblocking assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            pixel_column <= '0;
            pixel_row    <= '0;
            send_gap      = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                want_count = escape_time_of(pixel_column, pixel_row);
                counts_due.push_back(want_count);
                if (want_count < lo_count)
                begin
                    lo_count = want_count;
                end
                if (want_count > hi_count)
                begin
                    hi_count = want_count;
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pixel_q.size() != 0 &&
                         !(pixel_q[0].hold && counts_due.size() != 0))
                begin
                    next_pix      = pixel_q.pop_front();
                    in_valid     <= 1'b1;
                    pixel_column <= next_pix.col;
                    pixel_row    <= next_pix.row;
                    send_gap      = idle_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver. Every accepted beat is checked against the oldest
    // owed count. The stall pattern alternates runs of stall with runs of
    // free flow, so results land on every phase of the iteration loop.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            free_left  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (counts_due.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("ERROR: escape count %0d arrived with none owed",
                                 escape_count);
                    end
                    errors++;
                end
                else
                begin
                    want_count = counts_due.pop_front();
                    if (escape_count !== want_count)
                    begin
                        if (errors < 10)
                        begin
                            $display("ERROR: result %0d: escape_count expected %0d, got %0d",
                                     results_seen, want_count, escape_count);
                        end
                        errors++;
                    end
                end
            end
            if (quiet)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                stall_left = idle_len();
                free_left  = $urandom_range(0, 12);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog. The budget grows with every queued pixel, so the limit is
    // several times the slowest legal run of what was actually sent.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > 4 * cycle_budget + 20000)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int grid;
        int span;
        int rc;
        int ic;
        sh_real_min  = longint'(RST_REAL_MIN);
        sh_imag_min  = longint'(RST_IMAG_MIN);
        sh_real_step = longint'(RST_REAL_STEP);
        sh_imag_step = longint'(RST_IMAG_STEP);
        sh_max_iter  = longint'(RST_MAX_ITERATIONS);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset plane: a corner that escapes at once, the far corner whose
        // real and imaginary parts overflow and saturate, and the origin, which stays
        // inside and runs the full default limit. The origin waits for the
        // other two results before it is sent.
        queue_pixel(0, 0, 1'b0);
        queue_pixel(4095, 4095, 1'b0);
        queue_pixel(512, 512, 1'b1);

        // A zero iteration limit must behave like a limit of one.
        set_plane(-536870912, -536870912, 1048576, 1048576, 0);
        queue_pixel(512, 512, 1'b1);
        queue_pixel(0, 0, 1'b0);
        queue_pixel(256, 512, 1'b0);

        // Limit of one, with alternating bit patterns on both indexes.
        set_plane(-536870912, -402653184, 196608, 196608, 1);
        queue_pixel(2048, 2048, 1'b0);
        queue_pixel(12'hAAA, 12'h555, 1'b0);
        queue_pixel(12'h555, 12'hAAA, 1'b0);

        // Extreme edges and full steps with the largest limit: every c
        // lies on the edge of the range, one part high and one low or both, and
        // z escapes after the first iteration.
        set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 131071);
        queue_pixel(0, 0, 1'b0);
        queue_pixel(4095, 4095, 1'b0);
        queue_pixel(4095, 0, 1'b0);
        queue_pixel(0, 4095, 1'b0);

        // Zero steps put every pixel on the origin, so the limit above the
        // nominal maximum has to be honored in full.
        set_plane(0, 0, 0, 0, 131071);
        queue_pixel(12'hAAA, 12'h555, 1'b0);

        // Random planes. Each one picks a window over the set and a grid
        // size, and most pixels fall inside that grid so that the escape
        // counts spread out. The first plane runs with no idling at all,
        // and the last one uses raw random register values.
        for (int p = 0; p < 4; p++)
        begin
            grid = 1 << $urandom_range(4, 12);
            span = int'($urandom_range(1 << 24, 3 << 28));
            rc   = int'($urandom_range(0, 671088640)) - 536870912;
            ic   = int'($urandom_range(0, 671088640)) - 335544320;
            if (p == 3)
            begin
                set_plane($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 300));
            end
            else
            begin
                set_plane(rc - span / 2, ic - span / 2, span / grid, span / grid,
                          $urandom_range(1, 200));
            end
            quiet = (p == 0);
            for (int k = 0; k < 25; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    queue_pixel($urandom_range(0, grid - 1), $urandom_range(0, grid - 1),
                                $urandom_range(0, 99) < 5);
                end
                else
                begin
                    queue_pixel($urandom, $urandom, $urandom_range(0, 99) < 5);
                end
            end
        end

        drain();
        quiet = 1'b0;
        repeat (40) @(posedge clk);
        errors += counts_due.size();

        $display("Checked %0d pixels over %0d register settings, escape counts %0d to %0d.",
                 results_seen, settings, lo_count, hi_count);
        $display("Edges hit: zero, one and full iteration limits, saturated c, zero steps.");
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
